[rtl/stepped_sweep_tone_generator_top_macros.svh]
// Assertion macros shared by the tone generator RTL.
`ifndef STEPPED_SWEEP_TONE_GENERATOR_TOP_MACROS_SVH
`define STEPPED_SWEEP_TONE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSTG_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSTG_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sstg_pkg.sv]
// Package with types, constants and the sine table builder of the tone generator.
package sstg_pkg;

	// Default sizes of the datapath.
	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 24;

	// Fixed field widths.
	localparam int AMP_W       = 24;
	localparam int INC_W       = 32;
	localparam int TICK_W      = 16;
	localparam int COUNT_W     = 8;
	localparam int STEP_W      = 9;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int TAB_W       = 15;
	localparam int SINE_W      = TAB_W + 2;
	localparam int MUL_W       = INC_W + STEP_W;
	localparam int PROD_W      = AMP_W + 1 + SINE_W;
	localparam int FRAC_BITS   = 15;

	localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_AMPLITUDE      = 3'd0,
		CFG_BASE_INC       = 3'd1,
		CFG_STEP_INC       = 3'd2,
		CFG_TICKS_PER_STEP = 3'd3,
		CFG_STEP_COUNT     = 3'd4
	} cfg_index_t;

	// Reset values of the registers.
	localparam logic [AMP_W-1:0]   AMPLITUDE_RST      = 24'd8388608;
	localparam logic [INC_W-1:0]   BASE_INC_RST       = 32'd3579139;
	localparam logic [INC_W-1:0]   STEP_INC_RST       = 32'd8947849;
	localparam logic [TICK_W-1:0]  TICKS_PER_STEP_RST = 16'd100;
	localparam logic [COUNT_W-1:0] STEP_COUNT_RST     = 8'd8;

	// Current register contents, handed to the datapath as one group.
	typedef struct packed {
		logic [AMP_W-1:0]   amplitude;
		logic [INC_W-1:0]   base_increment;
		logic [INC_W-1:0]   step_increment;
		logic [TICK_W-1:0]  ticks_per_step;
		logic [COUNT_W-1:0] step_count;
	} cfg_t;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// Taylor series subtraction that stops at zero.
	function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
		return (a >= b) ? a - b : 64'd0;
	endfunction

	// Quarter-wave table entry i in unsigned Q0.15, evaluated at elaboration only.
	function automatic logic [TAB_W-1:0] quarter_sine(input int unsigned i,
		input int unsigned abits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x = (PI_Q30 * (64'(i) * 64'd2 + 64'd1)) >> (abits + 2);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		term = ((term * x2) >> 30) / 64'd6;   sum = sub_floor(sum, term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;  sum = sub_floor(sum, term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110; sum = sub_floor(sum, term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210; sum = sub_floor(sum, term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
		if (sum > ONE_Q30) sum = ONE_Q30;
		v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
		if (v > 64'd32767) v = 64'd32767;
		return v[TAB_W-1:0];
	endfunction

endpackage

[rtl/sstg_if.sv]
// Handshake channels of the tone generator: timer ticks in, tone samples out.
interface sstg_tick_if;
	logic valid;
	logic ready;
	logic fifo_has_space;

	modport source (output valid, output fifo_has_space, input ready);
	modport sink (input valid, input fifo_has_space, output ready);
endinterface

interface sstg_sample_if import sstg_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [STEP_W-1:0]             step_index;

	modport source (output valid, output sample, output step_index, input ready);
	modport sink (input valid, input sample, input step_index, output ready);
endinterface

[rtl/sstg_cfg_regs.sv]
// Configuration register file of the tone generator.
module sstg_cfg_regs import sstg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Register writes, truncated to each register's width; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude      <= AMPLITUDE_RST;
			cfg_q.base_increment <= BASE_INC_RST;
			cfg_q.step_increment <= STEP_INC_RST;
			cfg_q.ticks_per_step <= TICKS_PER_STEP_RST;
			cfg_q.step_count     <= STEP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_AMPLITUDE:      cfg_q.amplitude      <= cfg_wdata[AMP_W-1:0];
				CFG_BASE_INC:       cfg_q.base_increment <= cfg_wdata[INC_W-1:0];
				CFG_STEP_INC:       cfg_q.step_increment <= cfg_wdata[INC_W-1:0];
				CFG_TICKS_PER_STEP: cfg_q.ticks_per_step <= cfg_wdata[TICK_W-1:0];
				CFG_STEP_COUNT:     cfg_q.step_count     <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/sstg_phase_ctrl.sv]
// Tick counter, step index and phase accumulator; issues one phase per emitted sample.
`include "stepped_sweep_tone_generator_top_macros.svh"

module sstg_phase_ctrl import sstg_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	sstg_tick_if.sink             tick,
	output logic                  valid_s1,
	input  logic                  ready_dn,
	output logic [PHASE_BITS-1:0] phase_s1,
	output logic [STEP_W-1:0]     step_s1
);

	localparam int IW = (PHASE_BITS > MUL_W) ? PHASE_BITS : MUL_W;

	logic [TICK_W-1:0]     tick_q;
	logic [STEP_W-1:0]     step_q;
	logic [PHASE_BITS-1:0] phase_q;

	logic [TICK_W:0]       tick_next;
	logic                  fire;
	logic [STEP_W-1:0]     step_adv;
	logic [STEP_W-1:0]     step_mid;
	logic [STEP_W-1:0]     step_wrapped;
	logic [MUL_W-1:0]      step_mul;
	logic [IW-1:0]         inc_wide;
	logic [PHASE_BITS-1:0] phase_next;
	logic                  accept;
	logic                  emit;

	// Step decision and the next phase for a step tick.
	always_comb begin
		tick_next    = {1'b0, tick_q} + (TICK_W + 1)'(1);
		fire         = tick_next >= {1'b0, cfg.ticks_per_step};
		step_adv     = step_q + STEP_ONE;
		step_mid     = fire ? step_adv : step_q;
		step_wrapped = (step_mid > {1'b0, cfg.step_count}) ? STEP_ONE : step_mid;
		step_mul     = MUL_W'(cfg.step_increment) * MUL_W'(step_adv);
		inc_wide     = IW'(cfg.base_increment) + IW'(step_mul);
		phase_next   = phase_q + inc_wide[PHASE_BITS-1:0];
	end

	assign tick.ready = !valid_s1 || ready_dn;
	assign accept     = tick.valid && tick.ready;
	assign emit       = accept && fire && tick.fifo_has_space;

	// Generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			step_q  <= STEP_ONE;
			phase_q <= '0;
		end else if (accept) begin
			tick_q <= fire ? '0 : tick_next[TICK_W-1:0];
			step_q <= step_wrapped;
			if (emit) begin
				phase_q <= phase_next;
			end
		end
	end

	// Stage 1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= emit;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			phase_s1 <= phase_next;
			step_s1  <= step_adv;
		end
	end

	`SSTG_ASSERT_IMP(a_step_nonzero, 1'b1, step_q != '0, "step number reached zero")
	`SSTG_ASSERT_NXT(a_emit_valid, emit, valid_s1 && phase_s1 == $past(phase_next),
		"emitted phase did not reach stage 1")
	`SSTG_ASSERT_NXT(a_fire_clears, accept && fire, tick_q == '0,
		"tick counter not cleared on a step tick")
	`SSTG_ASSERT_IMP(a_step_range, valid_s1, step_s1 >= STEP_W'(2),
		"emitted step index below two")

endmodule

[rtl/sstg_sine_rom.sv]
// Quarter-wave sine table with registered read and quadrant folding.
module sstg_sine_rom import sstg_pkg::*; #(
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	output logic                  ready_up,
	input  logic [PHASE_BITS-1:0] phase_s1,
	input  logic [STEP_W-1:0]     step_s1,
	output logic                  valid_s2,
	input  logic                  ready_dn,
	output logic [TAB_W-1:0]      mag_s2,
	output logic                  neg_s2,
	output logic [STEP_W-1:0]     step_s2
);

	localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;

	logic [TAB_W-1:0]           rom [TABLE_SIZE];
	logic [TABLE_ADDR_BITS-1:0] addr_raw;
	logic [TABLE_ADDR_BITS-1:0] addr;
	logic                       load;

	// Table contents fixed at elaboration.
	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
		assign rom[g] = quarter_sine(g, TABLE_ADDR_BITS);
	end

	// Odd quadrants read the table mirrored.
	assign addr_raw = phase_s1[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	assign addr     = phase_s1[PHASE_BITS-2] ? ~addr_raw : addr_raw;
	assign ready_up = !valid_s2 || ready_dn;
	assign load     = valid_s1 && ready_up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_up) begin
			valid_s2 <= valid_s1;
		end
	end

	// Registered table read; the upper half cycle is negative.
	always_ff @(posedge clk) begin
		if (load) begin
			mag_s2  <= rom[addr];
			neg_s2  <= phase_s1[PHASE_BITS-1];
			step_s2 <= step_s1;
		end
	end

endmodule

[rtl/sstg_scale.sv]
// Amplitude scaling, floor shift and saturation into the output register.
module sstg_scale import sstg_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [AMP_W-1:0]   amplitude,
	input  logic               valid_s2,
	output logic               ready_up,
	input  logic [TAB_W-1:0]   mag_s2,
	input  logic               neg_s2,
	input  logic [STEP_W-1:0]  step_s2,
	sstg_sample_if.source      tone
);

	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	logic                          valid_s3;
	logic signed [SAMPLE_BITS-1:0] sample_s3;
	logic [STEP_W-1:0]             step_s3;

	logic signed [SINE_W-1:0]      sine;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      shifted;
	logic signed [SAMPLE_BITS-1:0] sat;

	// Signed sine, product, floor shift and clip to the sample range.
	always_comb begin
		sine    = neg_s2 ? -$signed({2'b00, mag_s2}) : $signed({2'b00, mag_s2});
		prod    = PROD_W'($signed({1'b0, amplitude}) * sine);
		shifted = prod >>> FRAC_BITS;
		if (shifted > SAT_HI) begin
			sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_LO) begin
			sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	assign ready_up = !valid_s3 || tone.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_up) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_up) begin
			sample_s3 <= sat;
			step_s3   <= step_s2;
		end
	end

	assign tone.valid      = valid_s3;
	assign tone.sample     = sample_s3;
	assign tone.step_index = step_s3;

endmodule

[rtl/stepped_sweep_tone_generator_top.sv]
// Stepped-sweep sine tone generator: top level.
//
// The tick channel takes one transaction per timer tick, carrying fifo_has_space.
// Every ticks_per_step ticks the step index advances; on such a tick with room,
// the phase grows by base_increment + step_increment * index and one transaction
// leaves the tone channel with the sample and the step index used. Other ticks
// produce nothing. The configuration port writes a register on any clock edge
// with cfg_we high; writes are meant for times when no sample is in flight.
// An accepted tick passes the accumulator stage, sine table read, then scaling
// into the output register. The three stages are held by a valid/ready chain, so
// while the receiver takes samples a tick can be accepted every cycle; the
// sustained rate is one tick per cycle, set by the accumulator loop.
// When the receiver stalls, samples wait in the pipeline registers and the tick
// channel keeps accepting until all three stages hold a sample and none can move.
// Reset (arst_n low) loads the register defaults, clears the tick counter and
// phase, sets the step index to one and empties the pipeline. The sine table
// is constant and needs no fill after reset.
module stepped_sweep_tone_generator_top import sstg_pkg::*; #(
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	sstg_tick_if.sink              tick,
	sstg_sample_if.source          tone
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic                  ready_s1;
	logic [PHASE_BITS-1:0] phase_s1;
	logic [STEP_W-1:0]     step_s1;
	logic                  valid_s2;
	logic                  ready_s2;
	logic [TAB_W-1:0]      mag_s2;
	logic                  neg_s2;
	logic [STEP_W-1:0]     step_s2;

	// Register file.
	sstg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Tick counter, step index and phase accumulator.
	sstg_phase_ctrl #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.tick     (tick),
		.valid_s1 (valid_s1),
		.ready_dn (ready_s1),
		.phase_s1 (phase_s1),
		.step_s1  (step_s1)
	);

	// Sine table lookup.
	sstg_sine_rom #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_up (ready_s1),
		.phase_s1 (phase_s1),
		.step_s1  (step_s1),
		.valid_s2 (valid_s2),
		.ready_dn (ready_s2),
		.mag_s2   (mag_s2),
		.neg_s2   (neg_s2),
		.step_s2  (step_s2)
	);

	// Scaling and output register.
	sstg_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (cfg.amplitude),
		.valid_s2  (valid_s2),
		.ready_up  (ready_s2),
		.mag_s2    (mag_s2),
		.neg_s2    (neg_s2),
		.step_s2   (step_s2),
		.tone      (tone)
	);

endmodule

[tb/sv/stepped_sweep_tone_generator_top_tb.sv]
// Self-checking testbench for the stepped-sweep tone generator top level.
module stepped_sweep_tone_generator_top_tb import sstg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF_NS = 5;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 3_000_000;
	localparam int IDLE_PERCENT = 18;
	localparam int STALL_PERCENT = 22;
	localparam int MAX_REPORTS = 10;
	localparam int QUARTER_SIZE = 1024;
	localparam int FIRST_SWEEP_TICKS = 270;
	localparam longint SAMPLE_MAX = 64'sd8388607;
	localparam longint SAMPLE_MIN = -64'sd8388608;
	localparam logic [63:0] PI_FIXED = 64'd3373259426;
	localparam logic [63:0] UNIT_FIXED = 64'd1 << 30;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	// One tone transaction as the checker sees it.
	typedef struct packed {
		logic signed [23:0] sample;
		logic [STEP_W-1:0]  step_index;
	} tone_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	sstg_tick_if   tick_ch();
	sstg_sample_if tone_ch();

	stepped_sweep_tone_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.tone      (tone_ch)
	);

	// Register copies and sweep state of the predictor.
	logic [AMP_W-1:0]   amp_r;
	logic [INC_W-1:0]   base_r;
	logic [INC_W-1:0]   step_inc_r;
	logic [TICK_W-1:0]  tps_r;
	logic [COUNT_W-1:0] count_r;
	logic [TICK_W-1:0]  sw_ticks;
	logic [STEP_W-1:0]  sw_step;
	logic [31:0]        sw_phase;
	int                 quarter_wave [QUARTER_SIZE];

	tone_t pending_tones [$];
	bit    steady;
	int    mismatches;
	int    tones_checked;
	int    ticks_sent;
	int    settings_applied;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Hard stop in case the design hangs.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// Quarter-wave entry i from a truncated Taylor series in Q30.
	function automatic int wave_entry(input int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x = (PI_FIXED * (64'(i) * 64'd2 + 64'd1)) >> 12;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
			if (k % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > UNIT_FIXED) sum = UNIT_FIXED;
		v = (sum * 64'd32767 + (UNIT_FIXED >> 1)) >> 30;
		if (v > 64'd32767) v = 64'd32767;
		return int'(v);
	endfunction

	// Signed sine value of a phase, folded from the quarter table.
	function automatic int sine_at(input logic [31:0] ph);
		logic [9:0] addr;
		logic [1:0] quad;
		int         mag;
		quad = ph[31:30];
		addr = ph[29:20];
		if (quad[0]) addr = 10'd1023 - addr;
		mag = quarter_wave[addr];
		return quad[1] ? -mag : mag;
	endfunction

	// Amplitude times sine, floored by 2^15 and clipped to 24 bits.
	function automatic logic signed [23:0] scale_tone(input int sine);
		longint prod;
		longint q;
		prod = longint'(amp_r) * longint'(sine);
		q = prod >>> 15;
		if (q > SAMPLE_MAX) q = SAMPLE_MAX;
		if (q < SAMPLE_MIN) q = SAMPLE_MIN;
		return q[23:0];
	endfunction

	// One timer tick; returns 1 when a tone sample is due.
	function automatic bit advance_sweep(input logic room, output tone_t res);
		logic [16:0]      nxt;
		logic [INC_W-1:0] inc;
		bit               fired;
		fired = 1'b0;
		res = '0;
		nxt = {1'b0, sw_ticks} + 17'd1;
		if (nxt >= {1'b0, tps_r}) begin
			sw_ticks = '0;
			sw_step = sw_step + 9'd1;
			if (room) begin
				inc = base_r + step_inc_r * 32'(sw_step);
				sw_phase = sw_phase + inc;
				res.sample = scale_tone(sine_at(sw_phase));
				res.step_index = sw_step;
				fired = 1'b1;
			end
		end else begin
			sw_ticks = nxt[15:0];
		end
		if (sw_step > {1'b0, count_r}) sw_step = 9'd1;
		return fired;
	endfunction

	// Receiver: random stalls except during the steady stretch.
	initial begin
		tone_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tone_ch.ready <= steady || ($urandom_range(99) >= STALL_PERCENT);
		end
	end

	// Compare every tone transaction with the oldest prediction.
	always @(posedge clk) begin
		tone_t want;
		if (arst_n && tone_ch.valid && tone_ch.ready) begin
			tones_checked++;
			if (pending_tones.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected tone: sample %0d step %0d",
						tone_ch.sample, tone_ch.step_index);
			end else begin
				want = pending_tones.pop_front();
				if (tone_ch.sample !== want.sample || tone_ch.step_index !== want.step_index) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("Tone mismatch: expected sample %0d step %0d, got sample %0d step %0d",
							want.sample, want.step_index, tone_ch.sample, tone_ch.step_index);
				end
			end
		end
	end

	// Send one tick transaction and record the sample it should cause.
	task automatic send_tick(input logic room);
		tone_t res;
		if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.fifo_has_space <= room;
		do @(posedge clk); while (!tick_ch.ready);
		ticks_sent++;
		if (advance_sweep(room, res)) pending_tones.push_back(res);
	endtask

	// Stop sending and let every pending sample and quiet tick drain out.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_tones.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Single register write, also applied to the predictor's register copy.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_AMPLITUDE: begin
				amp_r = val[AMP_W-1:0];
			end
			CFG_BASE_INC: begin
				base_r = val;
			end
			CFG_STEP_INC: begin
				step_inc_r = val;
			end
			CFG_TICKS_PER_STEP: begin
				tps_r = val[TICK_W-1:0];
			end
			CFG_STEP_COUNT: begin
				count_r = val[COUNT_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Full register setting; unused upper data bits carry random junk.
	task automatic configure(input logic [AMP_W-1:0] amp, input logic [INC_W-1:0] base,
		input logic [INC_W-1:0] sinc, input logic [TICK_W-1:0] tps, input logic [COUNT_W-1:0] cnt);
		settle();
		write_reg(CFG_AMPLITUDE, {8'($urandom), amp});
		write_reg(CFG_BASE_INC, base);
		write_reg(CFG_STEP_INC, sinc);
		write_reg(CFG_TICKS_PER_STEP, {16'($urandom), tps});
		write_reg(CFG_STEP_COUNT, {24'($urandom), cnt});
		settings_applied++;
	endtask

	// Reset defaults: slow sweep, a step every hundred ticks, with a sample when there is room.
	task automatic test_default_sweep();
		repeat (220) send_tick($urandom_range(99) < 90);
	endtask

	// Every tick steps; quadrant peaks with full-scale amplitude clip.
	task automatic test_every_tick_steps();
		configure(24'hFFFFFF, 32'h4000_0000, 32'h0, 16'd0, 8'd3);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		configure(24'h800000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 8'd255);
		repeat (3) send_tick(1'b1);
	endtask

	// Write data wider than a register is cut to its width.
	task automatic test_register_masking();
		settle();
		write_reg(CFG_AMPLITUDE, 32'hFF00_0000);
		write_reg(CFG_STEP_COUNT, 32'hFFFF_FF00);
		write_reg(CFG_TICKS_PER_STEP, 32'hFFFF_0001);
		repeat (3) send_tick(1'b1);
		settle();
		write_reg(CFG_AMPLITUDE, 32'hFF80_0000);
		repeat (3) send_tick(1'b1);
	endtask

	// Writes to indexes past the last register change nothing.
	task automatic test_unused_index();
		settle();
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, $urandom);
		repeat (2) send_tick(1'b1);
	endtask

	// A counter left above a lowered limit fires on the next tick.
	task automatic test_counter_above_limit();
		configure(24'h400000, 32'h0123_4567, 32'h0765_4321, 16'hFFFF, 8'd8);
		repeat (3) send_tick(1'b1);
		settle();
		write_reg(CFG_TICKS_PER_STEP, 32'd2);
		repeat (2) send_tick(1'b1);
	endtask

	// Without room the step still advances but the phase holds.
	task automatic test_no_room();
		configure(24'h7FFFFF, 32'h1000_0000, 32'h0200_0000, 16'd1, 8'd4);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
	endtask

	// Random register settings, each followed by a run of random ticks.
	task automatic test_random_sweeps(input int phases, input int ticks_each);
		logic [AMP_W-1:0]   amp;
		logic [INC_W-1:0]   base;
		logic [INC_W-1:0]   sinc;
		logic [TICK_W-1:0]  tps;
		logic [COUNT_W-1:0] cnt;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(3))
				0: amp = 24'hFFFFFF;
				1: amp = 24'h800000;
				default: amp = 24'($urandom);
			endcase
			base = ($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
			sinc = ($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
			tps = (p % 4 == 3) ? 16'($urandom_range(5, 30)) : 16'($urandom_range(0, 4));
			case ($urandom_range(4))
				0: cnt = 8'd255;
				1: cnt = 8'd0;
				default: cnt = 8'($urandom_range(1, 12));
			endcase
			// First phase walks the index all the way up to its top value.
			if (p == 0) begin
				tps = 16'd0;
				cnt = 8'd255;
			end
			configure(amp, base, sinc, tps, cnt);
			steady = (p == 2);
			repeat ((p == 0) ? FIRST_SWEEP_TICKS : ticks_each)
				send_tick($urandom_range(99) < 85);
			steady = 1'b0;
		end
	endtask

	// Reset, directed checks, random sweeps, then the verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.fifo_has_space <= 1'b0;
		steady = 1'b0;
		mismatches = 0;
		tones_checked = 0;
		ticks_sent = 0;
		settings_applied = 0;
		for (int i = 0; i < QUARTER_SIZE; i++) quarter_wave[i] = wave_entry(i);
		amp_r = AMPLITUDE_RST;
		base_r = BASE_INC_RST;
		step_inc_r = STEP_INC_RST;
		tps_r = TICKS_PER_STEP_RST;
		count_r = STEP_COUNT_RST;
		sw_ticks = '0;
		sw_step = STEP_ONE;
		sw_phase = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_sweep();
		test_every_tick_steps();
		test_register_masking();
		test_unused_index();
		test_counter_above_limit();
		test_no_room();
		test_random_sweeps(9, 150);
		settle();

		$display("Run covered %0d ticks, %0d tone samples checked, %0d register settings.",
			ticks_sent, tones_checked, settings_applied);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d tone mismatches in total.", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
